// File: rtl/core/color_temperature_from_spectral_assert.svh
// Assertion macros for the color temperature pipeline.
// Used by ctfs_div and color_temperature_from_spectral; no other dependencies.
`ifndef COLOR_TEMPERATURE_FROM_SPECTRAL_ASSERT_SVH
`define COLOR_TEMPERATURE_FROM_SPECTRAL_ASSERT_SVH

// same-cycle implication, off during reset
`define CTFS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ctfs: implication check failed");

// next-cycle implication, off during reset
`define CTFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ctfs: next-cycle check failed");

`endif

// File: rtl/core/ctfs_pkg.sv
// Shared types and constants of the color temperature pipeline.
// No dependencies; imported by ctfs_div, color_temperature_from_spectral, cct_checker and tb.
`timescale 1ns / 1ps

package ctfs_pkg;

	localparam int NUM_CH = 10;
	localparam int NUM_ROWS = 3;
	localparam int COEF_W = 22;
	localparam int FIELD_W = 16;
	localparam int INT_BITS = 4;   // integer quotient bits below the limit of 16

	// tristimulus matrix in units of 1e-5
	localparam logic signed [COEF_W-1:0] TRI_COEF [NUM_ROWS][NUM_CH] = '{
		'{22'sd39814, 22'sd129540, 22'sd36956, 22'sd10902, 22'sd71942,
		  22'sd178180, 22'sd110110, -22'sd3991, -22'sd27597, -22'sd2347},
		'{22'sd1396, 22'sd16748, 22'sd23538, 22'sd142750, 22'sd188670,
		  22'sd114200, 22'sd46497, -22'sd2702, -22'sd24468, -22'sd1993},
		'{22'sd195010, 22'sd645490, 22'sd278010, 22'sd18501, 22'sd15325,
		  22'sd9539, 22'sd10563, 22'sd8866, -22'sd61140, -22'sd938}
	};

	// n = (X - 0.3320 S) / (0.1858 S - Y), scaled by 1e4
	localparam int K_UNIT = 10000;
	localparam int K_XOFS = 3320;
	localparam int K_YOFS = 1858;

	// cubic coefficients
	localparam int K_C3 = 437;
	localparam int K_C2 = 3601;
	localparam int K_C1 = 6831;
	localparam int K_C0 = 5517;

	typedef struct packed {
		logic [FIELD_W-1:0] f1_count;
		logic [FIELD_W-1:0] f2_count;
		logic [FIELD_W-1:0] f3_count;
		logic [FIELD_W-1:0] f4_count;
		logic [FIELD_W-1:0] f5_count;
		logic [FIELD_W-1:0] f6_count;
		logic [FIELD_W-1:0] f7_count;
		logic [FIELD_W-1:0] f8_count;
		logic [FIELD_W-1:0] clear_count;
		logic [FIELD_W-1:0] nir_count;
	} reading_t;

	typedef struct packed {
		logic [FIELD_W-1:0] cct_kelvin;
		logic               degenerate;
	} result_t;

	// sideband carried alongside the quotient
	typedef struct packed {
		logic neg;
		logic degen;
	} div_side_t;

endpackage

// File: rtl/core/ctfs_div.sv
// Pipelined restoring divider: |num|/|den| in Q(FRAC_W), saturated at 16.
// Depends on ctfs_pkg and color_temperature_from_spectral_assert.svh.
`timescale 1ns / 1ps
`include "color_temperature_from_spectral_assert.svh"

module ctfs_div import ctfs_pkg::*; #(
	parameter int MAG_W = 56,
	parameter int FRAC_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [MAG_W-1:0]         a,
	input  logic [MAG_W-1:0]         d,
	input  div_side_t                in_side,
	output logic                     out_valid,
	output logic [FRAC_W+INT_BITS:0] quot,
	output div_side_t                out_side
);

	localparam int QB = FRAC_W + INT_BITS;
	localparam int R_W = MAG_W + INT_BITS + 1;
	localparam int NM_W = QB + 1;
	localparam logic [NM_W-1:0] NM_LIMIT = NM_W'(1) << QB;

	logic            v_s    [QB+1];
	logic [R_W-1:0]  rem_s  [QB+1];
	logic [R_W-1:0]  den_s  [QB+1];
	logic [QB-1:0]   quo_s  [QB+1];
	logic            sat_s  [QB+1];
	div_side_t       side_s [QB+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = R_W'(a);
	assign den_s[0]  = R_W'(d);
	assign quo_s[0]  = '0;
	assign sat_s[0]  = R_W'(a) >= (R_W'(d) << INT_BITS);
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [R_W-1:0] trial;
		logic [R_W-1:0] base;
		logic           ge;

		always_comb begin
			if (k < INT_BITS) begin
				base  = rem_s[k];
				trial = den_s[k] << (INT_BITS - 1 - k);
			end else begin
				base  = rem_s[k] << 1;
				trial = den_s[k];
			end
			ge = base >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? base - trial : base;
			den_s[k+1]  <= den_s[k];
			quo_s[k+1]  <= {quo_s[k][QB-2:0], ge};
			sat_s[k+1]  <= sat_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[QB];
	assign out_side  = side_s[QB];
	assign quot      = sat_s[QB] ? NM_LIMIT : {1'b0, quo_s[QB]};

	`CTFS_ASSERT_IMPLIES(a_quot_bound, clk, arst_n, out_valid && !out_side.degen, quot <= NM_LIMIT)

endmodule

// File: rtl/core/color_temperature_from_spectral.sv
// Correlated color temperature (McCamy cubic) from a ten-channel spectral reading.
// Path: s1 to s5, the divider, s6 to s9, then the output register that drives done.
// Throughput: one transaction per cycle; busy is tied low, the pipeline never stalls.
// Depth is set by the divider, one quotient bit per stage (FRACTION_BITS + 4 stages).
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on ctfs_pkg, ctfs_div and color_temperature_from_spectral_assert.svh.
`timescale 1ns / 1ps
`include "color_temperature_from_spectral_assert.svh"

module color_temperature_from_spectral import ctfs_pkg::*; #(
	parameter int CHANNEL_BITS = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  reading_t reading,
	output logic     done,
	output result_t  result
);

	// channel bits above the field width do not exist on the port
	localparam int CW = (CHANNEL_BITS < FIELD_W) ? CHANNEL_BITS : FIELD_W;
	localparam int F = FRACTION_BITS;
	localparam int PROD_W = CW + COEF_W + 1;   // product and tristimulus width
	localparam int S_W = PROD_W + 2;           // X+Y+Z
	localparam int NUM_W = S_W + 15;           // scaled numerator / denominator
	localparam int NM_W = F + INT_BITS + 1;    // |n|, up to 16.0
	localparam int N2_W = F + 9;               // n^2, up to 256.0
	localparam int N3_W = F + 13;              // |n^3|, up to 4096.0
	localparam int CUB_W = F + 25;             // signed cubic in Q(F)
	localparam int K_W = CUB_W - F;
	localparam logic [N2_W-1:0] N2_LIMIT = N2_W'(256) << F;

	// no stall anywhere: a transaction can enter every cycle
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic [CW-1:0] ch [NUM_CH];
	always_comb begin
		ch[0] = reading.f1_count[CW-1:0];
		ch[1] = reading.f2_count[CW-1:0];
		ch[2] = reading.f3_count[CW-1:0];
		ch[3] = reading.f4_count[CW-1:0];
		ch[4] = reading.f5_count[CW-1:0];
		ch[5] = reading.f6_count[CW-1:0];
		ch[6] = reading.f7_count[CW-1:0];
		ch[7] = reading.f8_count[CW-1:0];
		ch[8] = reading.clear_count[CW-1:0];
		ch[9] = reading.nir_count[CW-1:0];
	end

	// ---- s1: 30 constant products ----
	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s1 [NUM_ROWS][NUM_CH];

	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				prod_s1[r][c] <= PROD_W'(signed'({1'b0, ch[c]})) * PROD_W'(TRI_COEF[r][c]);
			end
		end
	end

	// ---- s2: tristimulus sums ----
	logic                     v_s2;
	logic signed [PROD_W-1:0] tri_s2 [NUM_ROWS];
	logic signed [PROD_W-1:0] tri_sum [NUM_ROWS];

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			tri_sum[r] = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				tri_sum[r] = tri_sum[r] + prod_s1[r][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		tri_s2 <= tri_sum;
	end

	// ---- s3: S = X+Y+Z ----
	logic                     v_s3;
	logic signed [S_W-1:0]    s_s3;
	logic signed [PROD_W-1:0] x_s3;
	logic signed [PROD_W-1:0] y_s3;

	always_ff @(posedge clk) begin
		s_s3 <= S_W'(tri_s2[0]) + S_W'(tri_s2[1]) + S_W'(tri_s2[2]);
		x_s3 <= tri_s2[0];
		y_s3 <= tri_s2[1];
	end

	// ---- s4: num = 1e4 X - 3320 S, den = 1858 S - 1e4 Y ----
	logic                    v_s4;
	logic signed [NUM_W-1:0] num_s4;
	logic signed [NUM_W-1:0] den_s4;
	logic                    zero_s4;

	always_ff @(posedge clk) begin
		num_s4  <= NUM_W'(x_s3) * NUM_W'(K_UNIT) - NUM_W'(s_s3) * NUM_W'(K_XOFS);
		den_s4  <= NUM_W'(s_s3) * NUM_W'(K_YOFS) - NUM_W'(y_s3) * NUM_W'(K_UNIT);
		zero_s4 <= (s_s3 == '0);
	end

	// ---- s5: magnitudes, quotient sign, degenerate gate ----
	logic             v_s5;
	logic [NUM_W-1:0] a_s5;
	logic [NUM_W-1:0] d_s5;
	div_side_t        side_s5;

	always_ff @(posedge clk) begin
		a_s5          <= num_s4[NUM_W-1] ? NUM_W'(-num_s4) : NUM_W'(num_s4);
		d_s5          <= den_s4[NUM_W-1] ? NUM_W'(-den_s4) : NUM_W'(den_s4);
		side_s5.neg   <= num_s4[NUM_W-1] ^ den_s4[NUM_W-1];
		side_s5.degen <= zero_s4 || (den_s4 == '0);
	end

	// ---- divider: one quotient bit per stage ----
	logic            v_dv;
	logic [NM_W-1:0] nm_dv;
	div_side_t       side_dv;

	ctfs_div #(
		.MAG_W  (NUM_W),
		.FRAC_W (F)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.a         (a_s5),
		.d         (d_s5),
		.in_side   (side_s5),
		.out_valid (v_dv),
		.quot      (nm_dv),
		.out_side  (side_dv)
	);

	// ---- s6: n^2 ----
	logic                 v_s6;
	logic [NM_W-1:0]      nm_s6;
	logic [N2_W-1:0]      n2_s6;
	div_side_t            side_s6;
	logic [2*NM_W-1:0]    sq;

	assign sq = (2*NM_W)'(nm_dv) * (2*NM_W)'(nm_dv);

	always_ff @(posedge clk) begin
		nm_s6   <= nm_dv;
		n2_s6   <= sq[F +: N2_W];
		side_s6 <= side_dv;
	end

	// ---- s7: |n^3| ----
	logic                   v_s7;
	logic [NM_W-1:0]        nm_s7;
	logic [N2_W-1:0]        n2_s7;
	logic [N3_W-1:0]        n3_s7;
	div_side_t              side_s7;
	logic [N2_W+NM_W-1:0]   cube;

	assign cube = (N2_W+NM_W)'(n2_s6) * (N2_W+NM_W)'(nm_s6);

	always_ff @(posedge clk) begin
		nm_s7   <= nm_s6;
		n2_s7   <= n2_s6;
		n3_s7   <= cube[F +: N3_W];
		side_s7 <= side_s6;
	end

	// ---- s8: signed cubic terms ----
	logic                    v_s8;
	logic signed [CUB_W-1:0] t3_s8;
	logic signed [CUB_W-1:0] t2_s8;
	logic signed [CUB_W-1:0] t1_s8;
	logic                    degen_s8;
	logic signed [CUB_W-1:0] t3m;
	logic signed [CUB_W-1:0] t1m;

	assign t3m = CUB_W'(signed'({1'b0, n3_s7})) * CUB_W'(K_C3);
	assign t1m = CUB_W'(signed'({1'b0, nm_s7})) * CUB_W'(K_C1);

	always_ff @(posedge clk) begin
		t3_s8    <= side_s7.neg ? -t3m : t3m;
		t1_s8    <= side_s7.neg ? -t1m : t1m;
		t2_s8    <= CUB_W'(signed'({1'b0, n2_s7})) * CUB_W'(K_C2);
		degen_s8 <= side_s7.degen;
	end

	// ---- s9: cubic sum in Q(F) ----
	logic                    v_s9;
	logic signed [CUB_W-1:0] cubic_s9;
	logic                    degen_s9;

	always_ff @(posedge clk) begin
		cubic_s9 <= t3_s8 + t2_s8 + t1_s8 + (CUB_W'(K_C0) <<< F);
		degen_s9 <= degen_s8;
	end

	// ---- output register: truncate and saturate, zero if degenerate or not positive ----
	logic [K_W-1:0] kel;
	result_t        res_next;
	result_t        result_q;
	logic           done_q;

	assign kel = cubic_s9[CUB_W-1:F];

	always_comb begin
		res_next.degenerate = degen_s9;
		if (degen_s9 || cubic_s9[CUB_W-1] || cubic_s9 == '0) begin
			res_next.cct_kelvin = '0;
		end else if (kel > K_W'({FIELD_W{1'b1}})) begin
			res_next.cct_kelvin = '1;
		end else begin
			res_next.cct_kelvin = kel[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_next;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_dv;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			done_q <= v_s9;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`CTFS_ASSERT_IMPLIES(a_degen_zero, clk, arst_n, done && result.degenerate, result.cct_kelvin == '0)
	`CTFS_ASSERT_IMPLIES(a_den_nonzero, clk, arst_n, v_s5 && !side_s5.degen, d_s5 != '0)
	`CTFS_ASSERT_IMPLIES(a_square_bound, clk, arst_n, v_s6 && !side_s6.degen, n2_s6 <= N2_LIMIT)

endmodule

// File: test/cct_checker.sv
// Checker for the color temperature pipeline: predicts each reading's result and compares.
// Depends on ctfs_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module cct_checker import ctfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  reading_t reading,
	input  logic     done,
	input  result_t  result,
	output int       fail_count,
	output int       pending
);

	localparam int FRAC = 16;
	localparam int N_CAP = 16;

	// matrix in units of 1e-5
	localparam longint MAT [3][10] = '{
		'{39814, 129540, 36956, 10902, 71942, 178180, 110110, -3991, -27597, -2347},
		'{1396, 16748, 23538, 142750, 188670, 114200, 46497, -2702, -24468, -1993},
		'{195010, 645490, 278010, 18501, 15325, 9539, 10563, 8866, -61140, -938}
	};

	result_t cct_queue[$];

	function automatic result_t predict_cct(reading_t rd);
		longint ch[10];
		longint xyz[3];
		longint s, num, den, n, n3, cubic;
		longint unsigned a, d, q, r, frac, nm, n2m, n3m, k;
		bit neg;
		result_t res;
		ch = '{rd.f1_count, rd.f2_count, rd.f3_count, rd.f4_count, rd.f5_count,
			rd.f6_count, rd.f7_count, rd.f8_count, rd.clear_count, rd.nir_count};
		for (int i = 0; i < 3; i++) begin
			xyz[i] = 0;
			for (int j = 0; j < 10; j++)
				xyz[i] += MAT[i][j] * ch[j];
		end
		s = xyz[0] + xyz[1] + xyz[2];
		num = 10000 * xyz[0] - 3320 * s;
		den = 1858 * s - 10000 * xyz[1];
		res = '0;
		if (s == 0 || den == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		neg = (num < 0) != (den < 0);
		a = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = a / d;
		r = a % d;
		if (q >= N_CAP) begin
			nm = longint'(N_CAP) << FRAC;
		end else begin
			frac = 0;
			for (int i = 0; i < FRAC; i++) begin
				r = r << 1;
				frac = frac << 1;
				if (r >= d) begin
					r -= d;
					frac |= 1;
				end
			end
			nm = (q << FRAC) | frac;
		end
		n2m = (nm * nm) >> FRAC;
		n3m = (n2m * nm) >> FRAC;
		n = neg ? -longint'(nm) : longint'(nm);
		n3 = neg ? -longint'(n3m) : longint'(n3m);
		cubic = 437 * n3 + 3601 * longint'(n2m) + 6831 * n + (longint'(5517) << FRAC);
		if (cubic > 0) begin
			k = longint'(cubic) >> FRAC;
			res.cct_kelvin = k > 65535 ? 16'hFFFF : k[15:0];
		end
		return res;
	endfunction

	assign pending = cct_queue.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			cct_queue.delete();
		end else begin
			if (done) begin
				if (cct_queue.size() == 0) begin
					$error("result with no transaction outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = cct_queue.pop_front();
					if (result.cct_kelvin !== want.cct_kelvin) begin
						$error("cct_kelvin: expected %0d, got %0d", want.cct_kelvin,
							result.cct_kelvin);
						fail_count <= fail_count + 1;
					end else if (result.degenerate !== want.degenerate) begin
						$error("degenerate: expected %0b, got %0b", want.degenerate,
							result.degenerate);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				cct_queue.push_back(predict_cct(reading));
		end
	end

endmodule

// File: test/tb.sv
// Top of the color temperature testbench: stimulus, idling, watchdog and verdict.
// Depends on ctfs_pkg, color_temperature_from_spectral and cct_checker.
`timescale 1ns / 1ps

module tb import ctfs_pkg::*;;

	localparam int LATENCY = 29;
	localparam int STALL_LIMIT = 2000;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     start = 0;
	logic     busy;
	reading_t reading = '0;
	logic     done;
	result_t  result;
	int       fail_count;
	int       pending;
	int       idle_pct = 27;
	int       sent = 0;
	int       quiet = 0;

	always #5 clk = ~clk;

	color_temperature_from_spectral uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.reading(reading), .done(done), .result(result)
	);

	cct_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .reading(reading),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	// watchdog: cycles in which no transaction moves on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// build a random reading: at times clear zeroed, all fields cut to their low byte, nir at full scale, or one nir bit
	function automatic reading_t rand_reading();
		reading_t rd;
		rd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 5))
			0: rd.clear_count = 0;
			1: rd = rd & {10{16'h00FF}};
			2: rd.nir_count = 16'hFFFF;
			3: rd = '0 | (16'(1) << $urandom_range(0, 15));
			default: ;
		endcase
		return rd;
	endfunction

	// hold start until the transaction is taken; sender idles at random beforehand
	task automatic send(reading_t rd);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		reading <= rd;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	initial begin
		reading_t dir[$];
		reading_t rd;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero sum, all max, single channels, clear-only (negative sum),
		// three two-channel mixes, and alternating bit patterns
		dir.push_back('0);
		dir.push_back('1);
		for (int i = 0; i < 10; i++) begin
			rd = '0;
			rd[16*i +: 16] = 16'hFFFF;
			dir.push_back(rd);
		end
		rd = '0; rd.clear_count = 16'd1; dir.push_back(rd);
		rd = '0; rd.f1_count = 16'd1; rd.f8_count = 16'hFFFF; dir.push_back(rd);
		rd = '0; rd.f4_count = 16'd100; rd.f3_count = 16'd100; dir.push_back(rd);
		rd = '0; rd.f8_count = 16'd5; rd.nir_count = 16'd3; dir.push_back(rd);
		dir.push_back({10{16'hAAAA}});
		dir.push_back({10{16'h5555}});
		foreach (dir[i]) send(dir[i]);

		for (int k = 0; k < 1035; k++) begin
			if (k == 345) idle_pct = 50;
			if (k == 690) idle_pct = 0;
			send(rand_reading());
		end
		start <= 1'b0;

		while (pending > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d readings: zero sum, extremes, single channels, random mixes,", sent);
		$display("with sender idling at 27%%, 50%% and none.");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: color_temperature_from_spectral.f
+incdir+rtl/core
rtl/core/ctfs_pkg.sv
rtl/core/ctfs_div.sv
rtl/core/color_temperature_from_spectral.sv
test/cct_checker.sv
test/tb.sv
